// ===== rtl/core/tgc_pkg.sv =====
package tgc_pkg;

    typedef enum logic [1:0] {
        ACT_CELL = 2'd0,
        ACT_FONT = 2'd1,
        ACT_EMIT = 2'd2
    } t_action;

    localparam logic [7:0] PIX_LIT  = 8'hFF;
    localparam logic [7:0] PIX_DARK = 8'h00;

    typedef struct packed {
        t_action     action;
        logic [4:0]  cell_row;
        logic [5:0]  cell_col;
        logic [7:0]  char_code;
        logic [6:0]  glyph_index;
        logic [2:0]  glyph_line;
        logic [4:0]  glyph_bits;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
        logic       frame_end;
        logic       write_done;
    } t_out;

endpackage

// ===== rtl/core/text_grid_character_generator.sv =====
// Channel | Direction | Handshake                          | Payload
// input   | in        | i_in_valid / o_in_stall            | i_in_data  (tgc_pkg::t_in)
// output  | out       | o_out_valid / i_out_stall          | o_out_data (tgc_pkg::t_out)
//
// One item per cycle sustained while the output is not stalled; each item's result passes
// through the grid RAM read, the font RAM read and the result register.
// Reset (synchronous, i_rst_n low) clears the raster position and starts a clear
// pass over both RAMs, one address per cycle, input stalled; the grid holds
// GRID_ROWS * 2**clog2(GRID_COLS) words (1792), the font GLYPH_COUNT * 2**clog2(GLYPH_HEIGHT) (1024).
// Each stage advances when the stage after it is empty or moving, so bubbles fill
// while the output is stalled.
module text_grid_character_generator #(
    parameter int GRID_ROWS    = 28,
    parameter int GRID_COLS    = 53,
    parameter int LINE_PIXELS  = 320,
    parameter int GLYPH_WIDTH  = 5,
    parameter int GLYPH_HEIGHT = 6,
    parameter int GLYPH_COUNT  = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  tgc_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output tgc_pkg::t_out o_out_data
);
    import tgc_pkg::*;

    localparam int CELL_W = GLYPH_WIDTH + 1;
    localparam int CELL_H = GLYPH_HEIGHT + 1;
    localparam int NCOL   = (LINE_PIXELS + CELL_W - 1) / CELL_W;
    localparam int XW     = $clog2(LINE_PIXELS);
    localparam int XCW    = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int LXW    = $clog2(CELL_W);
    localparam int LYW    = $clog2(CELL_H);
    localparam int RW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int GDEPTH = GRID_ROWS << CW;
    localparam int GAW    = $clog2(GDEPTH);
    localparam int LW     = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int GIW    = $clog2(GLYPH_COUNT);
    localparam int FDEPTH = GLYPH_COUNT << LW;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int CDEPTH = (GDEPTH > FDEPTH) ? GDEPTH : FDEPTH;
    localparam int CAW    = $clog2(CDEPTH);

    typedef struct packed {
        logic           emit;
        logic           blank;
        logic [LXW-1:0] lx;
        logic [LYW-1:0] ly;
        logic           line_end;
        logic           frame_end;
        logic           write_done;
    } t_meta;

    // raster position
    logic [XW-1:0]  r_x,   n_x;
    logic [LXW-1:0] r_lx,  n_lx;
    logic [XCW-1:0] r_col, n_col;
    logic [LYW-1:0] r_ly,  n_ly;
    logic [RW-1:0]  r_row, n_row;

    logic           r_clr;
    logic [CAW-1:0] r_clr_addr;

    logic  r_vb, r_vc, r_vd;
    t_meta r_mb, r_mc, n_mc, meta_a;
    t_out  r_out, n_out;

    logic en_b, en_c, en_d, accept;
    logic is_cell, is_font, is_emit, cell_ok, font_ok;
    logic last_x, last_lx, last_ly, last_row;

    logic             g_we, f_we;
    logic [GAW-1:0]   g_waddr, g_raddr;
    logic [7:0]       g_wdata, g_rdata;
    logic [FAW-1:0]   f_waddr, f_raddr;
    logic [GLYPH_WIDTH-1:0] f_wdata, f_rdata, f_shift;
    logic [GIW-1:0]   glyph;
    logic [LYW-1:0]   font_line;

    assign en_d       = !r_vd || !i_out_stall;
    assign en_c       = !r_vc || en_d;
    assign en_b       = !r_vb || en_c;
    assign o_in_stall = r_clr || !en_b;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        is_cell = 1'b0;
        is_font = 1'b0;
        is_emit = 1'b0;
        case (i_in_data.action)
            ACT_CELL: is_cell = 1'b1;
            ACT_FONT: is_font = 1'b1;
            ACT_EMIT: is_emit = 1'b1;
            default:  ;
        endcase
    end

    assign cell_ok = (int'(i_in_data.cell_row) < GRID_ROWS)
                  && (int'(i_in_data.cell_col) < GRID_COLS);
    assign font_ok = (int'(i_in_data.glyph_index) < GLYPH_COUNT)
                  && (int'(i_in_data.glyph_line) < GLYPH_HEIGHT);

    assign last_x   = r_x == XW'(LINE_PIXELS - 1);
    assign last_lx  = r_lx == LXW'(CELL_W - 1);
    assign last_ly  = r_ly == LYW'(CELL_H - 1);
    assign last_row = r_row == RW'(GRID_ROWS - 1);

    always_comb begin
        n_x   = r_x;
        n_lx  = r_lx;
        n_col = r_col;
        n_ly  = r_ly;
        n_row = r_row;
        if (accept && is_emit) begin
            if (last_x) begin
                n_x   = '0;
                n_lx  = '0;
                n_col = '0;
                if (last_ly) begin
                    n_ly  = '0;
                    n_row = last_row ? '0 : r_row + RW'(1);
                end else begin
                    n_ly = r_ly + LYW'(1);
                end
            end else begin
                n_x = r_x + XW'(1);
                if (last_lx) begin
                    n_lx  = '0;
                    n_col = r_col + XCW'(1);
                end else begin
                    n_lx = r_lx + LXW'(1);
                end
            end
        end
    end

    always_comb begin
        meta_a.emit       = is_emit;
        // top line of a cell, spacing column, or columns past the grid
        meta_a.blank      = (r_ly == '0) || (r_lx >= LXW'(GLYPH_WIDTH))
                         || (int'(r_col) >= GRID_COLS);
        meta_a.lx         = r_lx;
        meta_a.ly         = r_ly;
        meta_a.line_end   = is_emit && last_x;
        meta_a.frame_end  = is_emit && last_x && last_ly && last_row;
        meta_a.write_done = (is_cell && cell_ok) || (is_font && font_ok);
    end

    // RAM writes: clear pass after reset, else grid and font written at accept; grid read for the pixel at accept
    always_comb begin
        if (r_clr) begin
            g_we    = int'(r_clr_addr) < GDEPTH;
            g_waddr = GAW'(r_clr_addr);
            g_wdata = '0;
            f_we    = int'(r_clr_addr) < FDEPTH;
            f_waddr = FAW'(r_clr_addr);
            f_wdata = '0;
        end else begin
            g_we    = accept && is_cell && cell_ok;
            g_waddr = GAW'({RW'(i_in_data.cell_row), CW'(i_in_data.cell_col)});
            g_wdata = i_in_data.char_code;
            f_we    = accept && is_font && font_ok;
            f_waddr = FAW'({GIW'(i_in_data.glyph_index), LW'(i_in_data.glyph_line)});
            f_wdata = GLYPH_WIDTH'(i_in_data.glyph_bits);
        end
    end

    assign g_raddr = GAW'({r_row, CW'(r_col)});

    tgc_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (en_b),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    // stage B: code from the grid selects the font row
    assign glyph     = (int'(g_rdata) < GLYPH_COUNT) ? GIW'(g_rdata) : '0;
    assign font_line = r_mb.ly - LYW'(1);
    assign f_raddr   = FAW'({glyph, LW'(font_line)});

    always_comb begin
        n_mc       = r_mb;
        n_mc.blank = r_mb.blank || (g_rdata == 8'd0);
    end

    tgc_ram #(.WIDTH(GLYPH_WIDTH), .DEPTH(FDEPTH)) u_font (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (en_c),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // stage C: pick the pixel, leftmost is the top font bit
    assign f_shift = f_rdata >> (LXW'(GLYPH_WIDTH - 1) - r_mc.lx);

    always_comb begin
        n_out.pixel      = (r_mc.emit && !r_mc.blank && f_shift[0]) ? PIX_LIT : PIX_DARK;
        n_out.line_end   = r_mc.line_end;
        n_out.frame_end  = r_mc.frame_end;
        n_out.write_done = r_mc.write_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_lx       <= '0;
            r_col      <= '0;
            r_ly       <= '0;
            r_row      <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            r_vd       <= 1'b0;
        end else begin
            r_x   <= n_x;
            r_lx  <= n_lx;
            r_col <= n_col;
            r_ly  <= n_ly;
            r_row <= n_row;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + CAW'(1);
                if (r_clr_addr == CAW'(CDEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (en_b) begin
                r_vb <= accept;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_mb <= meta_a;
        end
        if (en_c) begin
            r_mc <= n_mc;
        end
        if (en_d) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vd;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/tgc_ram.sv =====
module tgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tgc_checker.sv =====
module tgc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input tgc_pkg::t_out i_out_data
);
    import tgc_pkg::*;

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_frame_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.frame_end |-> i_out_data.line_end)
        else $error("frame end without line end");

    a_write_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.write_done |->
            i_out_data.pixel == PIX_DARK && !i_out_data.line_end)
        else $error("write item carries raster fields");

    a_pixel_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.pixel == PIX_DARK || i_out_data.pixel == PIX_LIT)
        else $error("pixel neither lit nor dark");

endmodule

bind text_grid_character_generator tgc_checker u_tgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
